>>> design/utf8_unit_segmenter_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 unit segmenter assertion macros
// Shared concurrent assertion forms for the segmenter checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_UNIT_SEGMENTER_ASSERT_SVH
`define UTF8_UNIT_SEGMENTER_ASSERT_SVH

// Property checked at every rising clock edge, switched off while reset is high.
`define U8SEG_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define U8SEG_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/u8seg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 unit segmenter package
// Types, constants and byte classification functions shared by the design.
// ----------------------------------------------------------------------------
package u8seg_pkg;

   localparam int MAX_UNIT_BYTES = 4;
   localparam logic [7:0] REPLACEMENT_BYTE = 8'h80;

   // Output buffer: up to two results enter per request, one leaves per cycle while the response side is ready.
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic {
      CMD_BYTE  = 1'b0,
      CMD_FLUSH = 1'b1
   } command_type;

   typedef struct packed {
      logic [31:0] unit_bytes;
      logic [2:0]  unit_length;
      logic        replacement;
      logic        last_result;
   } rsp_item_type;

   // Length announced by a lead byte; anything else is a single-byte unit.
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd1;
      if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic logic is_continuation(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

endpackage

>>> design/u8seg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 unit segmenter channels
// Valid/ready request and response channels of the segmenter.
// ----------------------------------------------------------------------------
interface u8seg_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;
   logic       last_of_call;

   modport source (output valid, output command, output data_byte, output last_of_call,
                   input ready);
   modport sink   (input valid, input command, input data_byte, input last_of_call,
                   output ready);
endinterface

interface u8seg_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] unit_bytes;
   logic [2:0]  unit_length;
   logic        replacement;
   logic        last_result;

   modport source (output valid, output unit_bytes, output unit_length,
                   output replacement, output last_result, input ready);
   modport sink   (input valid, input unit_bytes, input unit_length,
                   input replacement, input last_result, output ready);
endinterface

>>> design/utf8_unit_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 unit segmenter
// Cuts a byte stream into UTF-8 units by lead-byte class and holds open
// tails across chunk ends, replacing interrupted tails by one marker.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   req_ch   in   valid/ready    command, data_byte, last_of_call
//   rsp_ch   out  valid/ready    unit_bytes, unit_length, replacement,
//                                last_result
//
// A request is classified and its results are written into a four-entry
// output buffer in the cycle it is accepted, so one request per cycle is
// taken as long as the buffer keeps room for two results.
// The buffer drains one response per cycle while rsp_ch.ready is high; the two
// results of one request leave one after the other through the single read port.
// The first response of a request is read from the registered output buffer, behind any responses already in it.
// Reset is synchronous and empties the buffer and closes any open unit.
// A stalled response side fills the buffer and then drops req_ch.ready.
// ----------------------------------------------------------------------------
module utf8_unit_segmenter (
   input logic        clock,
   input logic        reset,
   u8seg_req_if.sink   req_ch,
   u8seg_rsp_if.source rsp_ch
);

   // Open unit state. The held bytes are only read below the held count, so
   // they need no reset.
   logic [7:0] held_bytes_ff [u8seg_pkg::MAX_UNIT_BYTES];
   logic [2:0] held_count_ff, held_count_in;
   logic [2:0] expected_length_ff, expected_length_in;
   logic       carried_over_ff, carried_over_in;

   logic       held_wr_en;
   logic [1:0] held_wr_idx;

   // Output buffer, written at up to two places and read at its head.
   u8seg_pkg::rsp_item_type out_buf_ff [u8seg_pkg::OUT_DEPTH];
   logic [u8seg_pkg::OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [u8seg_pkg::OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [u8seg_pkg::OUT_CNT_W-1:0] count_ff, count_in;

   logic       req_accept;
   logic       rsp_pop;
   logic       is_cont;
   logic [2:0] lead_len;
   logic [2:0] held_count_inc;
   logic [31:0] pack_open;
   logic [31:0] pack_done;

   u8seg_pkg::rsp_item_type res0, res1;
   logic [1:0] num_res;

   // Accept only while two result slots are free, whatever the request causes.
   assign req_ch.ready = count_ff <= u8seg_pkg::OUT_CNT_W'(u8seg_pkg::OUT_DEPTH - 2);
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign is_cont        = u8seg_pkg::is_continuation(req_ch.data_byte);
   assign lead_len       = u8seg_pkg::lead_length(req_ch.data_byte);
   assign held_count_inc = held_count_ff + 3'd1;

   // Packed forms of the open unit: as it stands, and completed by the
   // incoming continuation byte. Unused high bytes read as zero.
   always_comb begin
      for (int i = 0; i < u8seg_pkg::MAX_UNIT_BYTES; i++) begin
         pack_open[8*i +: 8] = (3'(i) < held_count_ff) ? held_bytes_ff[i] : 8'h00;
         if (3'(i) < held_count_ff) begin
            pack_done[8*i +: 8] = held_bytes_ff[i];
         end else if (3'(i) == held_count_ff) begin
            pack_done[8*i +: 8] = req_ch.data_byte;
         end else begin
            pack_done[8*i +: 8] = 8'h00;
         end
      end
   end

   // Segmentation of one request. The results are compacted into res0 and
   // res1; num_res tells how many are real.
   always_comb begin
      logic take_lead;
      u8seg_pkg::rsp_item_type repl_item;
      u8seg_pkg::rsp_item_type byte_item;

      repl_item = '{unit_bytes: {24'h0, u8seg_pkg::REPLACEMENT_BYTE}, unit_length: 3'd1,
                    replacement: 1'b1, last_result: 1'b0};
      byte_item = '{unit_bytes: {24'h0, req_ch.data_byte}, unit_length: 3'd1,
                    replacement: 1'b0, last_result: 1'b0};

      take_lead          = 1'b0;
      held_count_in      = held_count_ff;
      expected_length_in = expected_length_ff;
      carried_over_in    = carried_over_ff;
      held_wr_en         = 1'b0;
      held_wr_idx        = 2'd0;
      res0               = '0;
      res1               = '0;
      num_res            = 2'd0;

      if (req_accept) begin
         if (req_ch.command == u8seg_pkg::CMD_FLUSH) begin
            // A flush replaces whatever unit is open, in or across chunks.
            if (held_count_ff != 3'd0) begin
               res0               = repl_item;
               num_res            = 2'd1;
               held_count_in      = 3'd0;
               expected_length_in = 3'd1;
               carried_over_in    = 1'b0;
            end
         end else begin
            take_lead = 1'b1;
            if (held_count_ff != 3'd0) begin
               if (is_cont && (held_count_ff < expected_length_ff)) begin
                  // Continuation extends the open unit.
                  take_lead   = 1'b0;
                  held_wr_en  = 1'b1;
                  held_wr_idx = held_count_ff[1:0];
                  if (held_count_inc >= expected_length_ff) begin
                     res0 = '{unit_bytes: pack_done, unit_length: held_count_inc,
                              replacement: 1'b0, last_result: 1'b0};
                     num_res            = 2'd1;
                     held_count_in      = 3'd0;
                     expected_length_in = 3'd1;
                     carried_over_in    = 1'b0;
                  end else begin
                     held_count_in = held_count_inc;
                     if (req_ch.last_of_call) begin
                        carried_over_in = 1'b1;
                     end
                  end
               end else begin
                  // Interrupted: a tail from an earlier chunk becomes one marker,
                  // a partial unit of this chunk goes out as it stands.
                  if (carried_over_ff) begin
                     res0 = repl_item;
                  end else begin
                     res0 = '{unit_bytes: pack_open, unit_length: held_count_ff,
                              replacement: 1'b0, last_result: 1'b0};
                  end
                  num_res            = 2'd1;
                  held_count_in      = 3'd0;
                  expected_length_in = 3'd1;
                  carried_over_in    = 1'b0;
               end
            end

            if (take_lead) begin
               if (lead_len == 3'd1) begin
                  if (num_res == 2'd0) begin
                     res0 = byte_item;
                  end else begin
                     res1 = byte_item;
                  end
                  num_res = num_res + 2'd1;
               end else begin
                  held_wr_en         = 1'b1;
                  held_wr_idx        = 2'd0;
                  held_count_in      = 3'd1;
                  expected_length_in = lead_len;
                  carried_over_in    = req_ch.last_of_call;
               end
            end
         end
      end

      res0.last_result = (num_res == 2'd1);
      res1.last_result = 1'b1;
   end

   // Open unit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff      <= 3'd0;
         expected_length_ff <= 3'd1;
         carried_over_ff    <= 1'b0;
      end else begin
         held_count_ff      <= held_count_in;
         expected_length_ff <= expected_length_in;
         carried_over_ff    <= carried_over_in;
      end
   end

   always_ff @(posedge clock) begin
      if (held_wr_en) begin
         held_bytes_ff[held_wr_idx] <= req_ch.data_byte;
      end
   end

   // Output buffer control.
   assign rsp_pop = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + u8seg_pkg::OUT_PTR_W'(num_res);
      rd_ptr_in = rd_ptr_ff + u8seg_pkg::OUT_PTR_W'(rsp_pop);
      count_in  = count_ff + u8seg_pkg::OUT_CNT_W'(num_res)
                  - u8seg_pkg::OUT_CNT_W'(rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (num_res != 2'd0) begin
         out_buf_ff[wr_ptr_ff] <= res0;
      end
      if (num_res == 2'd2) begin
         out_buf_ff[wr_ptr_ff + u8seg_pkg::OUT_PTR_W'(1)] <= res1;
      end
   end

   assign rsp_ch.valid       = count_ff != '0;
   assign rsp_ch.unit_bytes  = out_buf_ff[rd_ptr_ff].unit_bytes;
   assign rsp_ch.unit_length = out_buf_ff[rd_ptr_ff].unit_length;
   assign rsp_ch.replacement = out_buf_ff[rd_ptr_ff].replacement;
   assign rsp_ch.last_result = out_buf_ff[rd_ptr_ff].last_result;

endmodule

>>> design/u8seg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 unit segmenter checker
// Port-level assertions on the segmenter response channel, bound to the top.
// ----------------------------------------------------------------------------
`include "utf8_unit_segmenter_assert.svh"

module u8seg_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_unit_bytes,
   input logic [2:0]  rsp_unit_length,
   input logic        rsp_replacement,
   input logic        rsp_last_result
);

   // Reset empties the response buffer.
   `U8SEG_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "response after reset")

   // A unit holds one to four bytes, and bytes above its length are zero.
   `U8SEG_ASSERT(a_length_range, clock, reset,
      rsp_valid |-> (rsp_unit_length != 3'd0 && rsp_unit_length <= 3'd4
                     && (rsp_unit_length != 3'd1 || rsp_unit_bytes[31:8] == 24'h0)
                     && (rsp_unit_length != 3'd2 || rsp_unit_bytes[31:16] == 16'h0)
                     && (rsp_unit_length != 3'd3 || rsp_unit_bytes[31:24] == 8'h0)),
      "bad unit length or stray high bytes")

   // A replacement marker is always the lone marker byte.
   `U8SEG_ASSERT(a_replacement_form, clock, reset,
      (rsp_valid && rsp_replacement) |-> (rsp_unit_length == 3'd1
         && rsp_unit_bytes == {24'h0, u8seg_pkg::REPLACEMENT_BYTE}),
      "malformed replacement marker")

   // A stalled response keeps its value.
   `U8SEG_ASSERT(a_stall_holds, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_unit_bytes)
         && $stable(rsp_unit_length) && $stable(rsp_replacement)
         && $stable(rsp_last_result)),
      "stalled response changed")

endmodule

bind utf8_unit_segmenter u8seg_checker u_u8seg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_unit_bytes  (rsp_ch.unit_bytes),
   .rsp_unit_length (rsp_ch.unit_length),
   .rsp_replacement (rsp_ch.replacement),
   .rsp_last_result (rsp_ch.last_result)
);
